// ===== rtl/sm3_pkg.sv =====
package sm3_pkg;

    localparam logic [31:0] IV_WORDS [8] = '{
        32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
        32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
    };
    localparam logic [31:0] T_LOW    = 32'h79cc4519;
    localparam logic [31:0] T_HIGH   = 32'h7a879d8a;
    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam int          QUEUE_DEPTH = 4;

    // queued word for the back end: data, byte count, last flag
    typedef struct packed {
        logic [31:0] data;
        logic [2:0]  nbytes;
        logic        last;
    } sm3_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PUSH,
        ST_ROUND,
        ST_FOLD,
        ST_EMIT
    } back_state_t;

    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] dbl;
        dbl = {x, x} << n;
        return dbl[63:32];
    endfunction

    function automatic logic [31:0] perm0(input logic [31:0] v);
        return v ^ rotl(v, 5'd9) ^ rotl(v, 5'd17);
    endfunction

    function automatic logic [31:0] perm1(input logic [31:0] v);
        return v ^ rotl(v, 5'd15) ^ rotl(v, 5'd23);
    endfunction

endpackage

// ===== rtl/sm3_front.sv =====
module sm3_front
    import sm3_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_data,
    input  logic [2:0]  s_nbytes,
    input  logic        s_last,
    output logic        q_valid,
    input  logic        q_pop,
    output sm3_item_t   q_item
);
    localparam int PW = $clog2(QUEUE_DEPTH);

    sm3_item_t       mem [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]     count_reg;
    logic            push;
    logic            pop;
    sm3_item_t       cls;

    // non-last words count as four bytes, last words saturate at four
    always_comb
    begin
        cls.data   = s_data;
        cls.last   = s_last;
        if (!s_last)
            cls.nbytes = 3'd4;
        else if (s_nbytes > 3'd4)
            cls.nbytes = 3'd4;
        else
            cls.nbytes = s_nbytes;
    end

    assign s_tready = (count_reg != (PW+1)'(QUEUE_DEPTH));
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != '0);
    assign pop      = q_pop && q_valid;
    assign q_item   = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= cls;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_reg + (PW+1)'(push) - (PW+1)'(pop);
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (PW+1)'(QUEUE_DEPTH)) else $error("queue overflow");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count");
    a_nbytes_sat: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> cls.nbytes <= 3'd4) else $error("byte count");
`endif
endmodule

// ===== rtl/sm3_back.sv =====
module sm3_back
    import sm3_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    output logic        q_pop,
    input  sm3_item_t   q_item,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_word,
    output logic [2:0]  m_index,
    output logic        m_last
);
    back_state_t  state_reg, state_next;
    logic [31:0]  cv_reg [8];
    logic [31:0]  v_reg  [8];
    logic [31:0]  w_reg  [16];
    logic [63:0]  len_reg;
    logic [3:0]   pos_reg;
    logic [5:0]   rnd_reg;
    logic [2:0]   idx_reg;
    logic         fin_reg;      // padding in progress
    logic         lenhi_reg;    // next fill slot is the length
    sm3_item_t    cur_reg;
    logic         pad_pend_reg; // full last word, pad word still owed

    logic [31:0]  push_val;
    logic         push_en;
    logic         push_done;    // item fully loaded into window
    logic [31:0]  mask;
    logic [31:0]  a12, ss1, ss2, ff, gg, tt1, tt2, tj, wj, wpj, w_new;
    logic         lo16;

    // a block ends the message when its final word was the length low word
    function automatic logic push_done_last();
        return fin_reg && idx_reg == 3'd1;
    endfunction

    // message expansion on a rolling 16-word window
    assign w_new = perm1(w_reg[0] ^ w_reg[7] ^ rotl(w_reg[13], 5'd15))
                 ^ rotl(w_reg[3], 5'd7) ^ w_reg[10];
    assign wj    = w_reg[0];
    assign wpj   = w_reg[0] ^ w_reg[4];
    assign lo16  = (rnd_reg < 6'd16);
    assign tj    = lo16 ? T_LOW : T_HIGH;
    assign a12   = rotl(v_reg[0], 5'd12);
    assign ss1   = rotl(a12 + v_reg[4] + rotl(tj, rnd_reg[4:0]), 5'd7);
    assign ss2   = ss1 ^ a12;
    assign ff    = lo16 ? (v_reg[0] ^ v_reg[1] ^ v_reg[2])
                 : ((v_reg[0] & v_reg[1]) | (v_reg[0] & v_reg[2]) | (v_reg[1] & v_reg[2]));
    assign gg    = lo16 ? (v_reg[4] ^ v_reg[5] ^ v_reg[6])
                 : ((v_reg[4] & v_reg[5]) | (~v_reg[4] & v_reg[6]));
    assign tt1   = ff + v_reg[3] + ss2 + wpj;
    assign tt2   = gg + v_reg[7] + ss1 + wj;

    assign mask  = (cur_reg.nbytes == 3'd0) ? 32'h0
                 : (32'hffffffff << (6'd32 - {cur_reg.nbytes, 3'b000}));

    // select the word pushed this cycle in ST_PUSH
    always_comb
    begin
        push_val  = 32'h0;
        push_done = 1'b0;
        if (!fin_reg)
        begin
            if (!cur_reg.last)
            begin
                push_val  = cur_reg.data;
                push_done = 1'b1;
            end
            else if (cur_reg.nbytes == 3'd4)
                push_val = cur_reg.data;
            else
                push_val = (cur_reg.data & mask)
                         | ({24'h0, PAD_BYTE} << (5'd24 - {cur_reg.nbytes[1:0], 3'b000}));
        end
        else if (pad_pend_reg)
            push_val = {PAD_BYTE, 24'h0};
        else if (pos_reg == 4'd14 && lenhi_reg)
            push_val = len_reg[63:32];
        else if (pos_reg == 4'd15 && lenhi_reg)
        begin
            push_val  = len_reg[31:0];
            push_done = 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        push_en    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    state_next = ST_PUSH;
                end
            ST_PUSH:
            begin
                push_en = 1'b1;
                if (pos_reg == 4'd15)
                    state_next = ST_ROUND;
                else if (push_done)
                    state_next = ST_IDLE;
            end
            ST_ROUND:
                if (rnd_reg == 6'd63)
                    state_next = ST_FOLD;
            ST_FOLD:
                if (fin_reg && !pad_pend_reg && lenhi_reg && pos_reg == 4'd0 && idx_reg == 3'd7)
                    state_next = ST_EMIT;
                else if (push_done_last())
                    state_next = ST_EMIT;
                else if (fin_reg)
                    state_next = ST_PUSH;
                else
                    state_next = ST_IDLE;
            ST_EMIT:
                if (m_tready && idx_reg == 3'd7)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            len_reg      <= '0;
            pos_reg      <= '0;
            rnd_reg      <= '0;
            idx_reg      <= '0;
            fin_reg      <= 1'b0;
            lenhi_reg    <= 1'b0;
            pad_pend_reg <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                cv_reg[i] <= IV_WORDS[i];
                v_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_IDLE:
                    if (q_valid)
                    begin
                        len_reg <= len_reg + {58'h0, q_item.nbytes, 3'b000};
                        idx_reg <= '0;
                    end
                ST_PUSH:
                begin
                    pos_reg <= pos_reg + 1'b1;
                    if (cur_reg.last && !fin_reg)
                    begin
                        fin_reg      <= 1'b1;
                        pad_pend_reg <= (cur_reg.nbytes == 3'd4);
                        lenhi_reg    <= (cur_reg.nbytes != 3'd4) && (pos_reg == 4'd13);
                    end
                    else if (fin_reg)
                    begin
                        pad_pend_reg <= 1'b0;
                        lenhi_reg    <= (pos_reg == 4'd13) || (pos_reg == 4'd14 && lenhi_reg);
                        if (pos_reg == 4'd15 && lenhi_reg)
                            idx_reg <= 3'd1;
                    end
                    if (pos_reg == 4'd15)
                    begin
                        rnd_reg <= '0;
                        for (int i = 0; i < 8; i++)
                            v_reg[i] <= cv_reg[i];
                    end
                end
                ST_ROUND:
                begin
                    v_reg[7] <= v_reg[6];
                    v_reg[6] <= rotl(v_reg[5], 5'd19);
                    v_reg[5] <= v_reg[4];
                    v_reg[4] <= perm0(tt2);
                    v_reg[3] <= v_reg[2];
                    v_reg[2] <= rotl(v_reg[1], 5'd9);
                    v_reg[1] <= v_reg[0];
                    v_reg[0] <= tt1;
                    rnd_reg  <= rnd_reg + 1'b1;
                end
                ST_FOLD:
                begin
                    for (int i = 0; i < 8; i++)
                        cv_reg[i] <= cv_reg[i] ^ v_reg[i];
                    if (push_done_last())
                        idx_reg <= '0;
                end
                ST_EMIT:
                    if (m_tready)
                    begin
                        idx_reg <= idx_reg + 1'b1;
                        if (idx_reg == 3'd7)
                        begin
                            for (int i = 0; i < 8; i++)
                                cv_reg[i] <= IV_WORDS[i];
                            len_reg   <= '0;
                            pos_reg   <= '0;
                            fin_reg   <= 1'b0;
                            lenhi_reg <= 1'b0;
                        end
                    end
                default:
                    ;
            endcase
        end
    end

    // payload registers: item latch and message window
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && q_valid)
            cur_reg <= q_item;
        if (push_en)
            w_reg[pos_reg] <= push_val;
        else if (state_reg == ST_ROUND)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i+1];
            w_reg[15] <= w_new;
        end
    end

    assign m_tvalid = (state_reg == ST_EMIT);
    assign m_word   = cv_reg[idx_reg];
    assign m_index  = idx_reg;
    assign m_last   = (idx_reg == 3'd7);

`ifndef SYNTH
    a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ROUND |-> !q_pop) else $error("pop during rounds");
    a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(idx_reg)) else $error("emit hold");
    a_fold_after: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FOLD |-> $past(rnd_reg) == 6'd63) else $error("fold early");
`endif
endmodule

// ===== rtl/sm3_hash_engine_core.sv =====
// channel | dir | tdata (low bit up)                      | tuser | tlast
// s_axis  | in  | msg_word[31:0], word_bytes[34:32], pad  | -     | last_word
// m_axis  | out | digest_word[31:0], digest_index[34:32]  | -     | digest_last
// a word is loaded by a queue pop and then a window push; each 16-word block then runs
// the 64 rounds of the single round unit and a fold into the chaining value
// the last word adds padding loads, one or two blocks and eight digest words
// rst_n clears all control state asynchronously; chaining value goes to the iv
// a four-entry queue decouples input from the round engine; stalls on m_axis
// hold the digest word
module sm3_hash_engine_core
    import sm3_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // msg_word, word_bytes
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // digest_word, digest_index
    output logic        m_axis_tlast
);
    logic        q_valid, q_pop;
    sm3_item_t   q_item;
    logic [31:0] dw;
    logic [2:0]  di;

    sm3_front u_front (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_axis_tvalid), .s_tready(s_axis_tready),
        .s_data(s_axis_tdata[31:0]), .s_nbytes(s_axis_tdata[34:32]),
        .s_last(s_axis_tlast),
        .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item)
    );

    sm3_back u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item),
        .m_tvalid(m_axis_tvalid), .m_tready(m_axis_tready),
        .m_word(dw), .m_index(di), .m_last(m_axis_tlast)
    );

    assign m_axis_tdata = {5'b0, di, dw};
endmodule
